// ===== rtl/voc_pkg.sv =====
package voc_pkg;

  // Cells along each side of the chunk.
  localparam int EDGE = 16;
  localparam int CELLS = EDGE * EDGE * EDGE;
  localparam int ADDR_W = $clog2(CELLS);

  // Field widths.
  localparam int COORD_W = 4;
  localparam int NB_W = COORD_W + 1;
  localparam int KIND_W = 8;
  localparam int ORIGIN_W = 21;
  localparam int WORLD_W = 25;

  // Face neighbors and the resulting count width.
  localparam int NUM_FACES = 6;
  localparam int COUNT_W = $clog2(NUM_FACES + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;

  // Request codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  // Read sequence of one classify: the cell itself, then its six faces.
  typedef enum logic [2:0] {
    STEP_CENTER,
    STEP_XP,
    STEP_YP,
    STEP_ZP,
    STEP_XM,
    STEP_YM,
    STEP_ZM
  } step_t;

  // Grid address of one read and whether that cell lies inside the chunk.
  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
  } nbr_t;

  function automatic logic in_grid(input logic [NB_W-1:0] x, input logic [NB_W-1:0] y,
                                   input logic [NB_W-1:0] z);
    return (int'(x) < EDGE) && (int'(y) < EDGE) && (int'(z) < EDGE);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [NB_W-1:0] x,
                                                  input logic [NB_W-1:0] y,
                                                  input logic [NB_W-1:0] z);
    return ADDR_W'((int'(z) * EDGE + int'(y)) * EDGE + int'(x));
  endfunction

  // Origin in chunk units scaled to cells, plus the local offset, wrapped to 25 bits.
  function automatic logic [WORLD_W-1:0] world_coord(input logic [ORIGIN_W-1:0] origin,
                                                     input logic [COORD_W-1:0] local_c);
    logic signed [31:0] scaled;
    scaled = 32'($signed(origin)) * EDGE;
    return WORLD_W'(scaled + $signed({28'd0, local_c}));
  endfunction

endpackage

// ===== rtl/voc_cmd_if.sv =====
interface voc_cmd_if;
  import voc_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_y;
  logic [COORD_W-1:0] cell_z;
  logic [KIND_W-1:0]  block_kind;

  modport source (output valid, req_type, cell_x, cell_y, cell_z, block_kind, input ready);
  modport sink (input valid, req_type, cell_x, cell_y, cell_z, block_kind, output ready);
endinterface

// ===== rtl/voc_res_if.sv =====
interface voc_res_if;
  import voc_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  cell_kind;
  logic               visible;
  logic [WORLD_W-1:0] world_x;
  logic [WORLD_W-1:0] world_y;
  logic [WORLD_W-1:0] world_z;

  modport source (output valid, cell_kind, visible, world_x, world_y, world_z, input ready);
  modport sink (input valid, cell_kind, visible, world_x, world_y, world_z, output ready);
endinterface

// ===== rtl/voc_cfg_if.sv =====
interface voc_cfg_if;
  import voc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ORIGIN_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/voc_ram.sv =====
module voc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/voc_nbr.sv =====
module voc_nbr (
  input  logic [voc_pkg::COORD_W-1:0] cx,
  input  logic [voc_pkg::COORD_W-1:0] cy,
  input  logic [voc_pkg::COORD_W-1:0] cz,
  input  voc_pkg::step_t              step,
  output voc_pkg::nbr_t               nbr
);
  import voc_pkg::*;

  logic [NB_W-1:0] x0;
  logic [NB_W-1:0] y0;
  logic [NB_W-1:0] z0;
  logic [NB_W-1:0] nx;
  logic [NB_W-1:0] ny;
  logic [NB_W-1:0] nz;
  logic            low_ok;

  assign x0 = {1'b0, cx};
  assign y0 = {1'b0, cy};
  assign z0 = {1'b0, cz};

  // Offset the center by one along the axis of this step. A step toward
  // the low side is only legal when the coordinate is above zero.
  always_comb begin
    nx = x0;
    ny = y0;
    nz = z0;
    low_ok = 1'b1;
    unique case (step)
      STEP_CENTER: ;
      STEP_XP: nx = x0 + NB_W'(1);
      STEP_YP: ny = y0 + NB_W'(1);
      STEP_ZP: nz = z0 + NB_W'(1);
      STEP_XM: begin
        nx = x0 - NB_W'(1);
        low_ok = (cx != '0);
      end
      STEP_YM: begin
        ny = y0 - NB_W'(1);
        low_ok = (cy != '0);
      end
      STEP_ZM: begin
        nz = z0 - NB_W'(1);
        low_ok = (cz != '0);
      end
      default: low_ok = 1'b0;
    endcase
  end

  assign nbr.ok = low_ok && in_grid(nx, ny, nz);
  assign nbr.addr = cell_addr(nx, ny, nz);

endmodule

// ===== rtl/voxel_occlusion_classifier.sv =====
// Voxel occlusion classifier: holds a 16x16x16 grid of 8-bit block kinds (0 is
// empty) in one single-port RAM. A write item stores a kind at a cell and gives
// no result. A classify item reads the cell and then its six face neighbors
// through the one RAM port, one read per cycle, and returns the stored kind, a
// visible flag (non-empty with fewer than six face neighbors that are inside the
// chunk and non-empty, so occupied cells on the chunk surface are always
// visible) and the world coordinates, origin times EDGE plus the local
// coordinate, wrapped to 25 bits. Before the next item can be accepted, a
// classify passes through the accepting cycle, the seven RAM reads, a state for
// the last read data and one that loads the result register; the single RAM
// port makes the reads serial. The command channel is stalled further while a
// previous result still waits in the output register. After reset the block
// runs a clearing pass that writes every cell empty; no item is accepted during
// it, but configuration writes are taken at any time outside reset. The chunk
// origin registers must only be written while no item is in flight.
module voxel_occlusion_classifier (
  input logic clk,
  input logic rst,
  voc_cmd_if.sink   cmd,
  voc_res_if.source res,
  voc_cfg_if.sink   cfg
);
  import voc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_t;

  state_t state;

  // Clearing pass address.
  logic [ADDR_W-1:0] clr_addr;

  // Chunk origin registers.
  logic [ORIGIN_W-1:0] origin_x;
  logic [ORIGIN_W-1:0] origin_y;
  logic [ORIGIN_W-1:0] origin_z;

  // Classify context: the cell under test and the current read step.
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic [COORD_W-1:0] cur_z;
  step_t              step;

  // Tag of the read whose data shows up on the RAM output this cycle.
  logic  rd_live;
  step_t rd_step;
  logic  rd_ok;

  // Accumulated answer.
  logic [KIND_W-1:0]  stored;
  logic [COUNT_W-1:0] covered;

  // Result register.
  logic               res_valid;
  logic [KIND_W-1:0]  res_kind;
  logic               res_vis;
  logic [WORLD_W-1:0] res_wx;
  logic [WORLD_W-1:0] res_wy;
  logic [WORLD_W-1:0] res_wz;

  // RAM port.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [KIND_W-1:0] ram_wdata;
  logic [KIND_W-1:0] ram_rdata;

  nbr_t nbr;

  logic cmd_fire;
  logic wr_fire;
  logic out_free;

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = !rst;
  assign cmd_fire = cmd.valid && cmd.ready;

  // A write to a cell outside the chunk is dropped.
  assign wr_fire = cmd_fire && (cmd.req_type == REQ_WRITE) &&
                   in_grid({1'b0, cmd.cell_x}, {1'b0, cmd.cell_y}, {1'b0, cmd.cell_z});

  assign out_free = !res_valid || res.ready;

  assign res.valid = res_valid;
  assign res.cell_kind = res_kind;
  assign res.visible = res_vis;
  assign res.world_x = res_wx;
  assign res.world_y = res_wy;
  assign res.world_z = res_wz;

  voc_nbr u_nbr (
    .cx   (cur_x),
    .cy   (cur_y),
    .cz   (cur_z),
    .step (step),
    .nbr  (nbr)
  );

  // The single RAM port is shared by the clearing pass, writes and the
  // classify read sequence; the state decides who owns it.
  always_comb begin
    ram_we = 1'b0;
    ram_addr = nbr.addr;
    ram_wdata = cmd.block_kind;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_addr;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_we = wr_fire;
        ram_addr = cell_addr({1'b0, cmd.cell_x}, {1'b0, cmd.cell_y}, {1'b0, cmd.cell_z});
      end
      S_SCAN, S_LAST, S_DONE: ;
      default: ;
    endcase
  end

  voc_ram #(
    .WIDTH (KIND_W),
    .DEPTH (CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      step <= STEP_CENTER;
      rd_live <= 1'b0;
      res_valid <= 1'b0;
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          CFG_ORIGIN_X: origin_x <= cfg.data;
          CFG_ORIGIN_Y: origin_y <= cfg.data;
          CFG_ORIGIN_Z: origin_z <= cfg.data;
          default: ;
        endcase
      end

      // In the final state the result register is reloaded instead.
      if (res_valid && res.ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end

      // Consume the data of the read issued last cycle. The center read
      // gives the stored kind; each occupied in-chunk neighbor adds to the count.
      if (rd_live) begin
        if (rd_step == STEP_CENTER) begin
          stored <= rd_ok ? ram_rdata : '0;
        end else if (rd_ok && (ram_rdata != '0)) begin
          covered <= covered + COUNT_W'(1);
        end
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          rd_live <= 1'b0;
          if (cmd_fire && (cmd.req_type == REQ_CLASSIFY)) begin
            cur_x <= cmd.cell_x;
            cur_y <= cmd.cell_y;
            cur_z <= cmd.cell_z;
            step <= STEP_CENTER;
            covered <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_live <= 1'b1;
          rd_step <= step;
          rd_ok <= nbr.ok;
          if (step == STEP_ZM) begin
            state <= S_LAST;
          end else begin
            step <= step_t'(step + 3'd1);
          end
        end
        S_LAST: begin
          rd_live <= 1'b0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            res_valid <= 1'b1;
            res_kind <= stored;
            res_vis <= (stored != '0) && (int'(covered) < NUM_FACES);
            res_wx <= world_coord(origin_x, cur_x);
            res_wy <= world_coord(origin_y, cur_y);
            res_wz <= world_coord(origin_z, cur_z);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
